FILE: sv/debug_packet_deframer_macros.svh
// Assertion macros shared by the deframer checker.
`ifndef DEBUG_PACKET_DEFRAMER_MACROS_SVH
`define DEBUG_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DPD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, disabled while reset is low.
`define DPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

FILE: sv/dpd_pkg.sv
// Constants, types and helpers for the debug packet deframer.
package dpd_pkg;

  localparam logic [7:0] ChEscape  = 8'h7D;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] EscXor    = 8'h20;
  localparam logic [6:0] RunBias   = 7'd29;
  localparam logic [6:0] RunMax    = 7'd97;

  typedef enum logic [1:0] {
    ACK_NONE = 2'd0,
    ACK_PLUS = 2'd1,
    ACK_MINUS = 2'd2
  } ack_e;

  typedef struct packed {
    logic       bad;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t r;
    r.bad   = 1'b0;
    r.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.value = 4'(c - 8'h37);
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: sv/debug_packet_deframer.sv
// Debug packet deframer: decodes a remote-debug character stream into payload and end items.
//
// Usage:
//   s_axis: one received character per transaction, tdata[7:0] = rx_byte.
//   m_axis: one decoded item per transaction. A plain or escaped payload byte
//   comes out with repeat_count 1, a run with repeat_count 1..97, and the
//   packet end with tlast high, carrying checksum status and the ack to send.
//   Framing bytes, the checksum digits and bytes outside a packet give no item.
// Pipeline: a character is held in the input register, is decoded, and
//   its item is registered in the result register that drives m_axis.
// Throughput: one character per cycle unless m_axis stalls; the parser
//   state is updated by a single pass of compare and 8-bit add logic
//   between the input register and the state/result registers.
// Reset: the parser returns to hunting for '$' or '%', both stages empty.
// Stall: while m_axis_tready is low the result register holds; one more
//   character is taken into the input register, and a character that gives
//   no item is still consumed. Beyond that s_axis_tready drops.
module debug_packet_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [14:8] repeat_count,
                                      // [15] checksum_ok, [17:16] ack_code, rest 0
  output logic        m_axis_tlast,   // end_of_packet
  output logic        m_axis_tuser    // notification
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DATA   = 3'd1,
    PH_ESC    = 3'd2,
    PH_RUN    = 3'd3,
    PH_HI     = 3'd4,
    PH_LO     = 3'd5,
    PH_LO_BAD = 3'd6
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] prev_raw_q, prev_raw_d;
  logic       prev_valid_q, prev_valid_d;
  logic       notif_q, notif_d;
  logic [3:0] hi_q, hi_d;

  logic       in_valid_q;
  logic [7:0] in_byte_q;

  logic       out_valid_q;
  logic [7:0] out_data_q;
  logic [6:0] out_count_q;
  logic       out_end_q;
  logic       out_ok_q;
  logic       out_notif_q;
  logic [1:0] out_ack_q;

  logic       produce;
  logic       proc;
  logic [7:0] res_data;
  logic [6:0] res_count;
  logic       res_end;
  logic       res_ok;
  logic [1:0] res_ack;
  logic [7:0] b;
  dpd_pkg::hex_t hex;

  assign b   = in_byte_q;
  assign hex = dpd_pkg::hex_decode(in_byte_q);

  always_comb begin
    phase_d      = phase_q;
    sum_d        = sum_q;
    prev_raw_d   = prev_raw_q;
    prev_valid_d = prev_valid_q;
    notif_d      = notif_q;
    hi_d         = hi_q;
    produce      = 1'b0;
    res_data     = 8'd0;
    res_count    = 7'd0;
    res_end      = 1'b0;
    res_ok       = 1'b0;
    res_ack      = dpd_pkg::ACK_NONE;
    case (phase_q)
      PH_DATA: begin
        if (b == dpd_pkg::ChHash) begin
          phase_d = PH_HI;
        end else begin
          sum_d = sum_q + b;
          if (b == dpd_pkg::ChEscape) begin
            phase_d = PH_ESC;
          end else if (b == dpd_pkg::ChStar && prev_valid_q) begin
            phase_d = PH_RUN;
          end else begin
            prev_raw_d   = b;
            prev_valid_d = 1'b1;
            produce      = 1'b1;
            res_data     = b;
            res_count    = 7'd1;
          end
        end
      end
      PH_ESC: begin
        sum_d        = sum_q + b;
        prev_raw_d   = b;
        prev_valid_d = 1'b1;
        phase_d      = PH_DATA;
        produce      = 1'b1;
        res_data     = b ^ dpd_pkg::EscXor;
        res_count    = 7'd1;
      end
      PH_RUN: begin
        if (b == dpd_pkg::ChHash) begin
          phase_d = PH_HI;
        end else begin
          sum_d        = sum_q + b;
          prev_raw_d   = b;
          prev_valid_d = 1'b1;
          phase_d      = PH_DATA;
          // count characters 30..127 give a run; 127 saturates
          if (!b[7] && b[6:0] > dpd_pkg::RunBias) begin
            produce  = 1'b1;
            res_data = prev_raw_q;
            res_count = (b[6:0] == 7'h7F) ? dpd_pkg::RunMax : b[6:0] - dpd_pkg::RunBias;
          end
        end
      end
      PH_HI: begin
        hi_d    = hex.value;
        phase_d = hex.bad ? PH_LO_BAD : PH_LO;
      end
      PH_LO, PH_LO_BAD: begin
        res_ok  = (phase_q == PH_LO) && !hex.bad && ({hi_q, hex.value} == sum_q);
        res_end = 1'b1;
        produce = 1'b1;
        if (notif_q) begin
          res_ack = dpd_pkg::ACK_NONE;
        end else begin
          res_ack = res_ok ? dpd_pkg::ACK_PLUS : dpd_pkg::ACK_MINUS;
        end
        phase_d = PH_IDLE;
      end
      default: begin
        if (b == dpd_pkg::ChDollar || b == dpd_pkg::ChPercent) begin
          notif_d      = (b == dpd_pkg::ChPercent);
          sum_d        = 8'd0;
          prev_valid_d = 1'b0;
          prev_raw_d   = 8'd0;
          hi_d         = 4'd0;
          phase_d      = PH_DATA;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  // a character is consumed unless its item has nowhere to go
  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready || !produce);
  assign s_axis_tready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      sum_q        <= 8'd0;
      prev_raw_q   <= 8'd0;
      prev_valid_q <= 1'b0;
      notif_q      <= 1'b0;
      hi_q         <= 4'd0;
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (proc) begin
        phase_q      <= phase_d;
        sum_q        <= sum_d;
        prev_raw_q   <= prev_raw_d;
        prev_valid_q <= prev_valid_d;
        notif_q      <= notif_d;
        hi_q         <= hi_d;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc && produce) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
    if (proc && produce) begin
      out_data_q  <= res_data;
      out_count_q <= res_count;
      out_end_q   <= res_end;
      out_ok_q    <= res_ok;
      out_notif_q <= notif_q;
      out_ack_q   <= res_ack;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_ack_q, out_ok_q, out_count_q, out_data_q};
  assign m_axis_tlast  = out_end_q;
  assign m_axis_tuser  = out_notif_q;

endmodule

FILE: sv/dpd_checker.sv
// Port-level checker for the debug packet deframer, with its bind.
`include "debug_packet_deframer_macros.svh"

module dpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  logic        out_stall;
  logic        out_item;
  logic        out_end;
  logic [25:0] out_bus;
  logic [6:0]  out_count;
  logic        count_ok;
  logic [1:0]  end_ack;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_item  = m_axis_tvalid && !m_axis_tlast;
  assign out_end   = m_axis_tvalid && m_axis_tlast;
  assign out_bus   = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
  assign out_count = m_axis_tdata[14:8];
  assign count_ok  = (out_count != 7'd0) && (out_count <= dpd_pkg::RunMax);
  assign end_ack   = m_axis_tuser ? dpd_pkg::ACK_NONE :
                     (m_axis_tdata[15] ? dpd_pkg::ACK_PLUS : dpd_pkg::ACK_MINUS);

  `DPD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(out_bus))
  `DPD_ASSERT_SAME(a_end_empty, clk_i, rst_ni, out_end, m_axis_tdata[14:0] == 15'd0)
  `DPD_ASSERT_SAME(a_data_item, clk_i, rst_ni, out_item, count_ok && m_axis_tdata[23:15] == 9'd0)
  `DPD_ASSERT_SAME(a_end_ack, clk_i, rst_ni, out_end, m_axis_tdata[17:16] == end_ack)

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
